/* rtl/core/ptt_pkg.sv */
// ptt_pkg: shared types and constants for the periodic timer table
// holds command and result codes, item structs and the sequencer states
// no dependencies
package ptt_pkg;

  localparam int HANDLE_W   = 4;
  localparam int INTERVAL_W = 32;
  localparam int TIME_W     = 48;
  localparam int MAX_SLOTS  = 2 ** HANDLE_W;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_SET_IVL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FIRED    = 2'd0,
    KIND_ADDED    = 2'd1,
    KIND_ADD_FAIL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_ADD
  } state_t;

  typedef struct packed {
    cmd_t                  command;
    logic [HANDLE_W-1:0]   slot;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [TIME_W-1:0]     now_ms;
  } req_t;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   time_ms;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic tick;
    logic add;
  } time_req_t;

endpackage

/* rtl/core/ptt_ram.sv */
// ptt_ram: single write port, single read port synchronous memory
// read data is registered, valid in the cycle after the address
// depends on nothing
module ptt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ptt_time.sv */
// ptt_time: base time latch and cached relative time
// uses ptt_pkg for widths and the update request struct
module ptt_time
  import ptt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  time_req_t         treq,
  input  logic [TIME_W-1:0] now_ms,
  output logic [TIME_W-1:0] cached
);

  logic [TIME_W-1:0] base;
  logic [TIME_W-1:0] base_next;
  logic              base_unset;
  logic              upd;

  assign base_unset = (base == '0);
  assign upd        = treq.tick || (treq.add && base_unset);
  assign base_next  = base_unset ? now_ms : base;

  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      cached <= '0;
    end else if (upd) begin
      base   <= base_next;
      cached <= now_ms - base_next;
    end
  end

endmodule

/* rtl/core/periodic_timer_table.sv */
// periodic_timer_table: top level of the periodic timer table
// instantiates ptt_time and two ptt_ram memories, uses ptt_pkg
// holds the command sequencer, slot valid bits and result register
//
// Usage: commands enter on req (req_valid / req_stall), results leave on
// rsp (rsp_valid / rsp_stall). An item moves when valid is high and stall low.
// Tick scans the slots one per cycle while the scan is not paused (see below)
// through the due time and period memory read ports, and stalls further
// commands until the scan and flush are done. Fired results leave in
// ascending slot order, the last one flagged. Add gives one result;
// remove and set interval give none.
// A finished result waits in the output register while the next command is
// taken; when rsp_stall holds the register full, the scan pauses on the slot
// that has to emit and resumes once the register drains.
// Reset clears every slot valid bit, the base time and the cached time; the
// due time and period memories need no clearing.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SLOT_COUNT = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam int AW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IW         = $clog2(SLOT_COUNT + 1);

  state_t                state;
  state_t                state_next;
  logic [IW-1:0]         scan_idx;
  logic                  chk_vld;
  logic [AW-1:0]         chk_idx;
  logic                  hold_vld;
  logic [AW-1:0]         hold_idx;
  logic                  out_vld;
  rsp_t                  rsp_q;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [INTERVAL_W-1:0] ival;

  logic                  acc;
  logic                  in_range;
  logic [AW-1:0]         sidx;
  logic                  out_free;
  logic                  scan_more;
  logic                  fire;
  logic                  blocked;
  logic                  add_ok;
  logic                  free_found;
  logic [AW-1:0]         free_idx;
  logic                  load;
  rsp_t                  load_item;

  logic [AW-1:0]         raddr;
  logic [TIME_W-1:0]     due_q;
  logic [INTERVAL_W-1:0] per_q;
  logic                  due_we;
  logic [AW-1:0]         due_waddr;
  logic [TIME_W-1:0]     due_wdata;
  logic                  per_we;
  logic [AW-1:0]         per_waddr;
  logic [INTERVAL_W-1:0] per_wdata;

  time_req_t             treq;
  logic [TIME_W-1:0]     cached;

  assign req_stall = (state != ST_IDLE);
  assign acc       = req_valid && !req_stall;
  assign in_range  = (32'(req.slot) < SLOT_COUNT);
  assign sidx      = req.slot[AW-1:0];
  assign out_free  = !out_vld || !rsp_stall;
  assign scan_more = (scan_idx < IW'(SLOT_COUNT));
  assign add_ok    = free_found && (ival != '0);
  assign rsp_valid = out_vld;
  assign rsp       = rsp_q;

  assign treq.tick = acc && (req.command == CMD_TICK);
  assign treq.add  = acc && (req.command == CMD_ADD);

  ptt_time u_time (
    .clk    (clk),
    .rst    (rst),
    .treq   (treq),
    .now_ms (req.now_ms),
    .cached (cached)
  );

  ptt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (due_waddr),
    .wdata (due_wdata),
    .raddr (raddr),
    .rdata (due_q)
  );

  ptt_ram #(
    .WIDTH (INTERVAL_W),
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (raddr),
    .rdata (per_q)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && req.command == CMD_TICK) begin
          state_next = ST_SCAN;
        end else if (acc && req.command == CMD_ADD) begin
          state_next = ST_ADD;
        end
      end
      ST_SCAN: begin
        if (!blocked && !scan_more) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_vld || out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ADD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    raddr     = scan_idx[AW-1:0];
    fire      = 1'b0;
    blocked   = 1'b0;
    load      = 1'b0;
    load_item = '0;
    due_we    = 1'b0;
    due_waddr = chk_idx;
    due_wdata = due_q + TIME_W'(per_q);
    per_we    = 1'b0;
    per_waddr = sidx;
    per_wdata = req.interval_ms;
    case (state)
      ST_IDLE: begin
        per_we = acc && (req.command == CMD_SET_IVL) && in_range
                 && slot_valid[sidx] && (req.interval_ms != '0);
      end
      ST_SCAN: begin
        fire    = chk_vld && slot_valid[chk_idx] && (cached > due_q);
        blocked = fire && hold_vld && !out_free;
        due_we  = fire && !blocked;
        if (blocked) begin
          raddr = chk_idx;
        end
        if (fire && hold_vld && out_free) begin
          load              = 1'b1;
          load_item.kind    = KIND_FIRED;
          load_item.handle  = HANDLE_W'(hold_idx);
          load_item.time_ms = cached;
          load_item.last    = 1'b0;
        end
      end
      ST_FLUSH: begin
        if (hold_vld && out_free) begin
          load              = 1'b1;
          load_item.kind    = KIND_FIRED;
          load_item.handle  = HANDLE_W'(hold_idx);
          load_item.time_ms = cached;
          load_item.last    = 1'b1;
        end
      end
      ST_ADD: begin
        if (out_free) begin
          load              = 1'b1;
          load_item.time_ms = cached;
          load_item.last    = 1'b1;
          if (add_ok) begin
            load_item.kind   = KIND_ADDED;
            load_item.handle = HANDLE_W'(free_idx);
            due_we           = 1'b1;
            due_waddr        = free_idx;
            due_wdata        = cached;
            per_we           = 1'b1;
            per_waddr        = free_idx;
            per_wdata        = ival;
          end else begin
            load_item.kind   = KIND_ADD_FAIL;
            load_item.handle = '0;
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      chk_vld    <= 1'b0;
      hold_vld   <= 1'b0;
      out_vld    <= 1'b0;
      slot_valid <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        scan_idx <= '0;
        chk_vld  <= 1'b0;
      end else if (state == ST_SCAN && !blocked) begin
        chk_vld <= scan_more;
        if (scan_more) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (state == ST_SCAN && fire && !blocked) begin
        hold_vld <= 1'b1;
      end else if (state == ST_FLUSH && load) begin
        hold_vld <= 1'b0;
      end
      if (load) begin
        out_vld <= 1'b1;
      end else if (!rsp_stall) begin
        out_vld <= 1'b0;
      end
      if (acc && req.command == CMD_REMOVE && in_range) begin
        slot_valid[sidx] <= 1'b0;
      end else if (state == ST_ADD && out_free && add_ok) begin
        slot_valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && !blocked) begin
      chk_idx <= scan_idx[AW-1:0];
    end
    if (state == ST_SCAN && fire && !blocked) begin
      hold_idx <= chk_idx;
    end
    if (load) begin
      rsp_q <= load_item;
    end
    if (acc && req.command == CMD_ADD) begin
      ival <= req.interval_ms;
    end
  end

`ifndef SYNTHESIS
  a_hold_in_tick: assert property (@(posedge clk) disable iff (rst)
    hold_vld |-> (state == ST_SCAN || state == ST_FLUSH))
    else $error("held fired slot outside a tick");

  a_chk_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> (state == ST_SCAN))
    else $error("slot check active outside the scan");

  a_add_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD && out_free) |=> (rsp_valid && rsp.last))
    else $error("add finished without a final result");

  a_tick_to_scan: assert property (@(posedge clk) disable iff (rst)
    (acc && req.command == CMD_TICK) |=> (state == ST_SCAN && !chk_vld))
    else $error("tick did not start a fresh scan");
`endif

endmodule
